>>> hw/rtl/qdiw_pkg.sv
// Shared types, constants and the x4 transition decode for the quadrature
// decoder with interval window. No dependencies.
`default_nettype none

package qdiw_pkg;

    localparam int WINDOW_DEF = 8;
    localparam int WINDOW_MAX = 64;
    localparam int TIME_W     = 32;
    localparam int POS_W      = 32;
    localparam int SUM_W      = 35;
    localparam int TMO_W      = 16;
    localparam logic [TMO_W-1:0] STALL_TIMEOUT_RST = 16'd100;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    typedef struct packed {
        logic counted;
        t_dir dir;
    } t_step;

    // Code is {previous A, previous B, current A, current B}.
    function automatic t_dir decode_transition(input logic [3:0] code);
        t_dir dir;
        case (code) inside
            4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = DIR_CW;
            4'b0010, 4'b0100, 4'b1101, 4'b1011: dir = DIR_CCW;
            default:                            dir = DIR_NONE;
        endcase
        return dir;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qdiw_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module qdiw_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/qdiw_decode.sv
// Pin transition decode, previous pin pair and signed position counter.
// Depends on qdiw_pkg.
`default_nettype none

module qdiw_decode
    import qdiw_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_fire,
    input  wire logic                    i_a_level,
    input  wire logic                    i_b_level,
    output t_step                        o_step,
    output logic signed [POS_W-1:0]      o_position
);

    logic [1:0]              r_prev_pins;
    logic [1:0]              n_prev_pins;
    logic signed [POS_W-1:0] r_position;
    logic signed [POS_W-1:0] n_position;
    t_dir                    dir;

    assign n_prev_pins = {i_a_level, i_b_level};
    assign dir         = decode_transition({r_prev_pins, n_prev_pins});

    always_comb begin
        case (dir)
            DIR_CW:  n_position = r_position + POS_W'(1);
            DIR_CCW: n_position = r_position - POS_W'(1);
            default: n_position = r_position;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins <= '0;
            r_position  <= '0;
        end else if (i_fire) begin
            r_prev_pins <= n_prev_pins;
            r_position  <= n_position;
        end
    end

    assign o_step.counted = (dir != DIR_NONE);
    assign o_step.dir     = dir;
    assign o_position     = n_position;

endmodule

`default_nettype wire

>>> hw/rtl/qdiw_window.sv
// Ring of step intervals with running sum, last step time and stall check.
// Depends on qdiw_pkg and qdiw_ram.
`default_nettype none

module qdiw_window
    import qdiw_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire t_step             i_step,
    input  wire logic [TIME_W-1:0] i_time_now,
    input  wire logic [TMO_W-1:0]  i_stall_timeout,
    output logic      [TIME_W-1:0] o_last_interval,
    output logic      [SUM_W-1:0]  o_interval_sum,
    output logic                   o_moving
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [IDX_W:0] WRAP = (IDX_W + 1)'(WINDOW);

    logic [TIME_W-1:0] r_last_time;
    logic [TIME_W-1:0] n_last_time;
    logic [TIME_W-1:0] r_last_int;
    logic [TIME_W-1:0] n_last_int;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [IDX_W-1:0]  r_oldest;
    logic [IDX_W-1:0]  n_oldest;
    logic [WINDOW-1:0] r_valid;
    logic [WINDOW-1:0] n_valid;
    logic              r_byp;
    logic [TIME_W-1:0] r_byp_data;
    logic              r_rd_valid;

    logic              we;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] oldest_val;
    logic [TIME_W-1:0] ram_rdata;
    logic [TIME_W-1:0] idle_time;
    logic [IDX_W:0]    slot_inc;

    assign we        = i_fire && i_step.counted;
    assign interval  = i_time_now - r_last_time;
    assign idle_time = i_time_now - r_last_time;
    assign slot_inc  = {1'b0, r_oldest} + (IDX_W + 1)'(1);

    // Entry at the oldest slot: fresh write bypass, then RAM, zero if never written.
    assign oldest_val = r_byp ? r_byp_data : (r_rd_valid ? ram_rdata : '0);

    always_comb begin
        n_last_time = r_last_time;
        n_last_int  = r_last_int;
        n_sum       = r_sum;
        n_oldest    = r_oldest;
        n_valid     = r_valid;
        if (we) begin
            n_last_time       = i_time_now;
            n_last_int        = interval;
            n_sum             = r_sum - {{(SUM_W-TIME_W){1'b0}}, oldest_val}
                                      + {{(SUM_W-TIME_W){1'b0}}, interval};
            n_oldest          = (slot_inc == WRAP) ? '0 : slot_inc[IDX_W-1:0];
            n_valid[r_oldest] = 1'b1;
        end
    end

    qdiw_ram #(
        .WIDTH  (TIME_W),
        .DEPTH  (WINDOW),
        .ADDR_W (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_oldest),
        .i_wdata (interval),
        .i_raddr (n_oldest),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_last_int  <= '0;
            r_sum       <= '0;
            r_oldest    <= '0;
            r_valid     <= '0;
            r_byp       <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_last_time <= n_last_time;
            r_last_int  <= n_last_int;
            r_sum       <= n_sum;
            r_oldest    <= n_oldest;
            r_valid     <= n_valid;
            // Read of the slot just written returns old data; take it from here.
            r_byp       <= we && (n_oldest == r_oldest);
            r_rd_valid  <= n_valid[n_oldest];
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= interval;
    end

    assign o_last_interval = n_last_int;
    assign o_interval_sum  = n_sum;
    assign o_moving        = i_step.counted
                             || (idle_time <= {{(TIME_W-TMO_W){1'b0}}, i_stall_timeout});

endmodule

`default_nettype wire

>>> hw/rtl/quadrature_decoder_interval_window_top.sv
// Top level of the x4 quadrature decoder with interval window.
// Depends on qdiw_pkg, qdiw_decode, qdiw_window and qdiw_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one pin sample: levels of
//   A and B and a 32-bit timestamp. Output channel (o_out_valid / i_out_ready)
//   returns exactly one result per sample: position, step direction, newest
//   interval, sum of the last WINDOW intervals and the moving flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   stall timeout; it is always ready and should be used only while idle.
//   Path: each sample is held in the input register, then decoded and written
//   to the result register once that register is empty or being read.
//   Throughput: one sample per cycle while i_out_ready is high, set by the
//   single decode-and-update stage between the input and result registers.
//   Reset (synchronous, active low) clears position, pin history, the ring
//   valid bits, sum and last step time, and sets the timeout to 100. When
//   the receiver stalls, the result register holds its data and the input
//   register takes one more sample before o_in_ready drops.
`default_nettype none

module quadrature_decoder_interval_window_top
    import qdiw_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [TMO_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_a_level,
    input  wire logic                 i_b_level,
    input  wire logic [TIME_W-1:0]    i_time_now,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [POS_W-1:0]   o_position,
    output logic [1:0]                o_step_dir,
    output logic [TIME_W-1:0]         o_last_interval,
    output logic [SUM_W-1:0]          o_interval_sum,
    output logic                      o_moving
);

    logic [TMO_W-1:0]        r_timeout;
    logic                    r_in_valid;
    logic                    r_a;
    logic                    r_b;
    logic [TIME_W-1:0]       r_time;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_position;
    logic [1:0]              r_dir;
    logic [TIME_W-1:0]       r_last_int;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_moving;

    logic                    fire;
    logic                    in_ready;
    t_step                   step;
    logic signed [POS_W-1:0] n_position;
    logic [TIME_W-1:0]       n_last_int;
    logic [SUM_W-1:0]        n_sum;
    logic                    n_moving;

    assign fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign in_ready = !r_in_valid || fire;

    qdiw_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_a_level  (r_a),
        .i_b_level  (r_b),
        .o_step     (step),
        .o_position (n_position)
    );

    qdiw_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_step          (step),
        .i_time_now      (r_time),
        .i_stall_timeout (r_timeout),
        .o_last_interval (n_last_int),
        .o_interval_sum  (n_sum),
        .o_moving        (n_moving)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= STALL_TIMEOUT_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on transaction, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_a    <= i_a_level;
            r_b    <= i_b_level;
            r_time <= i_time_now;
        end
        if (fire) begin
            r_position <= n_position;
            r_dir      <= step.dir;
            r_last_int <= n_last_int;
            r_sum      <= n_sum;
            r_moving   <= n_moving;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_position      = r_position;
    assign o_step_dir      = r_dir;
    assign o_last_interval = r_last_int;
    assign o_interval_sum  = r_sum;
    assign o_moving        = r_moving;

endmodule

`default_nettype wire
